/* src/htsl_pkg.sv */
// ----------------------------------------------------------------------------
// htsl_pkg
// Types and constants shared by the heater thermostat and safety latch.
// ----------------------------------------------------------------------------
package htsl_pkg;

    localparam int TEMP_W   = 12;
    localparam int RETRY_W  = 4;
    localparam int BLINK_W  = 16;
    localparam int MSG_W    = 3;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // reset values of the configuration registers
    localparam logic [TEMP_W-1:0]  RST_CRITICAL  = 12'd1200;
    localparam logic [TEMP_W-1:0]  RST_STOP      = 12'd800;
    localparam logic [TEMP_W-1:0]  RST_START     = 12'd760;
    localparam logic [TEMP_W-1:0]  RST_NOT_READY = 12'd600;
    localparam logic [RETRY_W-1:0] RST_RETRY     = 4'd5;
    localparam logic [BLINK_W-1:0] RST_BLINK     = 16'd1000;

    localparam logic [RETRY_W-1:0] MISSING_MAX   = 4'hF;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_BLOCK = 2'd1,
        ACT_CASE  = 2'd2
    } t_action;

    typedef enum logic [MSG_W-1:0] {
        MSG_NONE     = 3'd0,
        MSG_HEATING  = 3'd1,
        MSG_READY    = 3'd2,
        MSG_OVERHEAT = 3'd3,
        MSG_PROBE    = 3'd4,
        MSG_CASE     = 3'd5
    } t_msg;

    typedef enum logic [2:0] {
        REG_CRITICAL  = 3'd0,
        REG_STOP      = 3'd1,
        REG_START     = 3'd2,
        REG_NOT_READY = 3'd3,
        REG_RETRY     = 3'd4,
        REG_BLINK     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic             heater_on;
        logic             status_red;
        logic             error_light;
        logic             halted;
        logic [MSG_W-1:0] message;
    } t_result;

endpackage

/* src/heater_thermostat_safety_latch.sv */
// ----------------------------------------------------------------------------
// heater_thermostat_safety_latch
// Bang-bang heater control with hysteresis and a latched overtemp/sensor/case halt.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     i_valid / o_stall      i_action, i_block_temp, i_block_fault,
//                                   i_case_missing
//  output    o_valid / i_stall      o_heater_on, o_status_red, o_error_light,
//                                   o_halted, o_message
//  config    psel/penable/pwrite    paddr, pwdata, prdata, pready (always 1)
//
//  one request per cycle while o_stall is low: the state update is a single pass of
//  compare logic into the state registers, and the result enters a two-entry output
//  queue; the result is visible in the cycle after acceptance when the queue is empty
//  o_stall rises only when both queue entries hold results not yet taken
//  synchronous active-low reset restores the register defaults and clears state
module heater_thermostat_safety_latch (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_action,
    input  logic [htsl_pkg::TEMP_W-1:0]      i_block_temp,
    input  logic                             i_block_fault,
    input  logic                             i_case_missing,
    // output channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_heater_on,
    output logic                             o_status_red,
    output logic                             o_error_light,
    output logic                             o_halted,
    output logic [htsl_pkg::MSG_W-1:0]       o_message,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [htsl_pkg::ADDR_W-1:0]      paddr,
    input  logic [htsl_pkg::DATA_W-1:0]      pwdata,
    output logic [htsl_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);

    // configuration registers
    logic [htsl_pkg::TEMP_W-1:0]  r_critical;
    logic [htsl_pkg::TEMP_W-1:0]  r_stop;
    logic [htsl_pkg::TEMP_W-1:0]  r_start;
    logic [htsl_pkg::TEMP_W-1:0]  r_not_ready;
    logic [htsl_pkg::RETRY_W-1:0] r_retry;
    logic [htsl_pkg::BLINK_W-1:0] r_blink_period;

    // control state
    logic                         r_halt,    n_halt;
    logic                         r_heater,  n_heater;
    logic                         r_status,  n_status;
    logic                         r_error,   n_error;
    logic [htsl_pkg::RETRY_W-1:0] r_missing, n_missing;
    logic [htsl_pkg::BLINK_W-1:0] r_blink,   n_blink;
    logic [htsl_pkg::MSG_W-1:0]   r_msg,     n_msg;

    // output queue
    htsl_pkg::t_result            r_q [2];
    logic                         r_wr_ptr;
    logic                         r_rd_ptr;
    logic [1:0]                   r_count;

    logic                         in_acc;
    logic                         out_acc;
    logic                         cfg_wr;
    logic [2:0]                   reg_idx;
    logic [htsl_pkg::BLINK_W-1:0] blink_inc;
    logic [htsl_pkg::RETRY_W-1:0] missing_inc;
    htsl_pkg::t_result            n_res;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[htsl_pkg::ADDR_W-1:2];
    assign pready  = 1'b1;

    assign blink_inc   = r_blink + 16'd1;
    assign missing_inc = r_missing + 4'd1;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_critical     <= htsl_pkg::RST_CRITICAL;
            r_stop         <= htsl_pkg::RST_STOP;
            r_start        <= htsl_pkg::RST_START;
            r_not_ready    <= htsl_pkg::RST_NOT_READY;
            r_retry        <= htsl_pkg::RST_RETRY;
            r_blink_period <= htsl_pkg::RST_BLINK;
        end else if (cfg_wr && paddr[1:0] == 2'b00) begin
            unique case (reg_idx)
                htsl_pkg::REG_CRITICAL:  r_critical     <= pwdata[htsl_pkg::TEMP_W-1:0];
                htsl_pkg::REG_STOP:      r_stop         <= pwdata[htsl_pkg::TEMP_W-1:0];
                htsl_pkg::REG_START:     r_start        <= pwdata[htsl_pkg::TEMP_W-1:0];
                htsl_pkg::REG_NOT_READY: r_not_ready    <= pwdata[htsl_pkg::TEMP_W-1:0];
                htsl_pkg::REG_RETRY:     r_retry        <= pwdata[htsl_pkg::RETRY_W-1:0];
                htsl_pkg::REG_BLINK:     r_blink_period <= pwdata[htsl_pkg::BLINK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (reg_idx)
                htsl_pkg::REG_CRITICAL:  prdata = {20'd0, r_critical};
                htsl_pkg::REG_STOP:      prdata = {20'd0, r_stop};
                htsl_pkg::REG_START:     prdata = {20'd0, r_start};
                htsl_pkg::REG_NOT_READY: prdata = {20'd0, r_not_ready};
                htsl_pkg::REG_RETRY:     prdata = {28'd0, r_retry};
                htsl_pkg::REG_BLINK:     prdata = {16'd0, r_blink_period};
                default:                 prdata = '0;
            endcase
        end
    end

    // ---------------- event handling ----------------
    always_comb begin
        n_halt    = r_halt;
        n_heater  = r_heater;
        n_status  = r_status;
        n_error   = r_error;
        n_missing = r_missing;
        n_blink   = r_blink;
        n_msg     = r_msg;
        if (in_acc) begin
            unique case (i_action)
                htsl_pkg::ACT_TICK: begin
                    if (r_halt) begin
                        if (blink_inc >= r_blink_period) begin
                            n_error = !r_error;
                            n_blink = '0;
                        end else begin
                            n_blink = blink_inc;
                        end
                    end
                end
                htsl_pkg::ACT_BLOCK: begin
                    if (i_block_fault) begin
                        n_halt   = 1'b1;
                        n_status = 1'b1;
                        n_msg    = htsl_pkg::MSG_PROBE;
                    end else if (!r_halt) begin
                        if (i_block_temp >= r_critical) begin
                            n_halt   = 1'b1;
                            n_status = 1'b1;
                            n_msg    = htsl_pkg::MSG_OVERHEAT;
                        end else begin
                            if (i_block_temp >= r_stop) begin
                                n_heater = 1'b0;
                                n_status = 1'b0;
                                n_msg    = htsl_pkg::MSG_READY;
                            end else if (i_block_temp <= r_start) begin
                                n_heater = 1'b1;
                                n_msg    = htsl_pkg::MSG_HEATING;
                            end
                            if (i_block_temp < r_not_ready) begin
                                n_status = 1'b1;
                            end
                        end
                    end
                end
                htsl_pkg::ACT_CASE: begin
                    if (i_case_missing) begin
                        // count saturates and stops triggering at full scale
                        if (r_missing != htsl_pkg::MISSING_MAX) begin
                            n_missing = missing_inc;
                            if (missing_inc == r_retry) begin
                                n_halt   = 1'b1;
                                n_status = 1'b1;
                                n_msg    = htsl_pkg::MSG_CASE;
                            end
                        end
                    end else begin
                        n_missing = '0;
                    end
                end
                default: ;
            endcase
        end
        if (n_halt) begin
            n_heater = 1'b0;
        end
    end

    always_comb begin
        n_res.heater_on   = n_heater;
        n_res.status_red  = n_status;
        n_res.error_light = n_error;
        n_res.halted      = n_halt;
        n_res.message     = n_msg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halt    <= 1'b0;
            r_heater  <= 1'b0;
            r_status  <= 1'b1;
            r_error   <= 1'b0;
            r_missing <= '0;
            r_blink   <= '0;
            r_msg     <= htsl_pkg::MSG_NONE;
        end else begin
            r_halt    <= n_halt;
            r_heater  <= n_heater;
            r_status  <= n_status;
            r_error   <= n_error;
            r_missing <= n_missing;
            r_blink   <= n_blink;
            r_msg     <= n_msg;
        end
    end

    // ---------------- output queue ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_q[r_wr_ptr] <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (in_acc) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (out_acc) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (in_acc && !out_acc) begin
                r_count <= r_count + 2'd1;
            end else if (!in_acc && out_acc) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign o_valid       = (r_count != 2'd0);
    assign o_stall       = (r_count == 2'd2);
    assign o_heater_on   = r_q[r_rd_ptr].heater_on;
    assign o_status_red  = r_q[r_rd_ptr].status_red;
    assign o_error_light = r_q[r_rd_ptr].error_light;
    assign o_halted      = r_q[r_rd_ptr].halted;
    assign o_message     = r_q[r_rd_ptr].message;

endmodule

/* src/htsl_checker.sv */
// ----------------------------------------------------------------------------
// htsl_checker
// Port-level checks for the heater thermostat and safety latch.
// ----------------------------------------------------------------------------
module htsl_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic                        o_heater_on,
    input logic                        o_status_red,
    input logic                        o_halted,
    input logic [htsl_pkg::MSG_W-1:0]  o_message
);

    // heater is never driven while the halt is latched
    a_no_heat_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_halted |-> !o_heater_on)
        else $error("heater on while halted");

    // halt shows red status
    a_red_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_halted |-> o_status_red)
        else $error("status not red while halted");

    // once a halted result is taken, later results stay halted
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_halted |=> !o_valid || o_halted)
        else $error("halt released without reset");

    // input is held off only while results wait
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_message) && $stable(o_halted))
        else $error("stalled result changed");

endmodule

bind heater_thermostat_safety_latch htsl_checker u_htsl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_heater_on  (o_heater_on),
    .o_status_red (o_status_red),
    .o_halted     (o_halted),
    .o_message    (o_message)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the heater thermostat and safety latch. A scoreboard
// class mirrors the thermostat state, predicts the status of every accepted
// request and compares it with each result taken from the block. The run walks
// through several register settings with the heater running, then latches an
// overheat halt and keeps going while halted to exercise blinking and relatching.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         HOLD_CYCLES = 60;

    // scoreboard: thermostat state mirror and queue of expected status
    class thermo_scoreboard;
        logic [htsl_pkg::TEMP_W-1:0]  crit, stop_lvl, start_lvl, ready_lvl;
        logic [htsl_pkg::RETRY_W-1:0] retry;
        logic [htsl_pkg::BLINK_W-1:0] blink_per;
        bit                           halt, heat, red, err;
        logic [htsl_pkg::RETRY_W-1:0] miss_cnt;
        logic [htsl_pkg::BLINK_W-1:0] blink_cnt;
        htsl_pkg::t_msg               msg;
        htsl_pkg::t_result            expected_status_q[$];
        int                           n_checked, n_bad, n_latch, n_toggle;
        int                           n_by_act[4];

        function new();
            crit      = htsl_pkg::RST_CRITICAL;
            stop_lvl  = htsl_pkg::RST_STOP;
            start_lvl = htsl_pkg::RST_START;
            ready_lvl = htsl_pkg::RST_NOT_READY;
            retry     = htsl_pkg::RST_RETRY;
            blink_per = htsl_pkg::RST_BLINK;
            halt      = 1'b0;
            heat      = 1'b0;
            red       = 1'b1;
            err       = 1'b0;
            miss_cnt  = '0;
            blink_cnt = '0;
            msg       = htsl_pkg::MSG_NONE;
        endfunction

        function int pending();
            return expected_status_q.size();
        endfunction

        function void set_reg(htsl_pkg::t_reg_idx idx, logic [htsl_pkg::DATA_W-1:0] v);
            case (idx)
                htsl_pkg::REG_CRITICAL:  crit      = v[htsl_pkg::TEMP_W-1:0];
                htsl_pkg::REG_STOP:      stop_lvl  = v[htsl_pkg::TEMP_W-1:0];
                htsl_pkg::REG_START:     start_lvl = v[htsl_pkg::TEMP_W-1:0];
                htsl_pkg::REG_NOT_READY: ready_lvl = v[htsl_pkg::TEMP_W-1:0];
                htsl_pkg::REG_RETRY:     retry     = v[htsl_pkg::RETRY_W-1:0];
                htsl_pkg::REG_BLINK:     blink_per = v[htsl_pkg::BLINK_W-1:0];
                default: ;
            endcase
        endfunction

        function void latch_halt(htsl_pkg::t_msg why);
            halt = 1'b1;
            heat = 1'b0;
            red  = 1'b1;
            msg  = why;
            n_latch++;
        endfunction

        function void note_request(logic [1:0] act, logic [htsl_pkg::TEMP_W-1:0] temp,
                                   logic fault, logic miss);
            htsl_pkg::t_result status;
            n_by_act[act]++;
            if (act == htsl_pkg::ACT_TICK) begin
                if (halt) begin
                    blink_cnt = blink_cnt + 1'b1;
                    if (blink_cnt >= blink_per) begin
                        err = !err;
                        blink_cnt = '0;
                        n_toggle++;
                    end
                end
            end else if (act == htsl_pkg::ACT_BLOCK) begin
                if (fault) begin
                    latch_halt(htsl_pkg::MSG_PROBE);
                end else if (!halt) begin
                    if (temp >= crit) begin
                        latch_halt(htsl_pkg::MSG_OVERHEAT);
                    end else begin
                        // hysteresis band between start and stop keeps the drive
                        if (temp >= stop_lvl) begin
                            heat = 1'b0;
                            red  = 1'b0;
                            msg  = htsl_pkg::MSG_READY;
                        end else if (temp <= start_lvl) begin
                            heat = 1'b1;
                            msg  = htsl_pkg::MSG_HEATING;
                        end
                        if (temp < ready_lvl)
                            red = 1'b1;
                    end
                end
            end else if (act == htsl_pkg::ACT_CASE) begin
                if (miss) begin
                    // count saturates, so a full count never triggers again
                    if (miss_cnt < htsl_pkg::MISSING_MAX) begin
                        miss_cnt = miss_cnt + 1'b1;
                        if (miss_cnt == retry)
                            latch_halt(htsl_pkg::MSG_CASE);
                    end
                end else begin
                    miss_cnt = '0;
                end
            end
            if (halt)
                heat = 1'b0;
            status.heater_on   = heat;
            status.status_red  = red;
            status.error_light = err;
            status.halted      = halt;
            status.message     = msg;
            expected_status_q.push_back(status);
        endfunction

        function void check_result(htsl_pkg::t_result got);
            htsl_pkg::t_result want;
            n_checked++;
            if (expected_status_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("error: result %0d arrived with no request waiting", n_checked);
                return;
            end
            want = expected_status_q.pop_front();
            if (got.heater_on !== want.heater_on || got.status_red !== want.status_red ||
                got.error_light !== want.error_light || got.halted !== want.halted ||
                got.message !== want.message) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $write("error: result %0d exp/act heater %b/%b red %b/%b ",
                           n_checked, want.heater_on, got.heater_on,
                           want.status_red, got.status_red);
                    $display("err %b/%b halted %b/%b message %0d/%0d",
                             want.error_light, got.error_light,
                             want.halted, got.halted, want.message, got.message);
                end
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [1:0]                    i_action = htsl_pkg::ACT_TICK;
    logic [htsl_pkg::TEMP_W-1:0]   i_block_temp = '0;
    logic                          i_block_fault = 1'b0;
    logic                          i_case_missing = 1'b0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic                          o_heater_on, o_status_red, o_error_light, o_halted;
    logic [htsl_pkg::MSG_W-1:0]    o_message;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [htsl_pkg::ADDR_W-1:0]   paddr = '0;
    logic [htsl_pkg::DATA_W-1:0]   pwdata = '0;
    logic [htsl_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    thermo_scoreboard sb = new();
    bit src_gaps  = 1'b1;
    bit sink_gaps = 1'b1;
    bit hold_go   = 1'b0;
    int hold_left = 0;
    int n_writes  = 0;

    heater_thermostat_safety_latch u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_block_temp   (i_block_temp),
        .i_block_fault  (i_block_fault),
        .i_case_missing (i_case_missing),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_heater_on    (o_heater_on),
        .o_status_red   (o_status_red),
        .o_error_light  (o_error_light),
        .o_halted       (o_halted),
        .o_message      (o_message),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver: random stalls plus an occasional long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= sink_gaps && ($urandom_range(99) < 29);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall)
            sb.check_result({o_heater_on, o_status_red, o_error_light, o_halted, o_message});
    end

    task automatic send_request(logic [1:0] act, logic [htsl_pkg::TEMP_W-1:0] temp,
                                logic fault, logic miss);
        while (src_gaps && $urandom_range(99) < 29) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= act;
        i_block_temp   <= temp;
        i_block_fault  <= fault;
        i_case_missing <= miss;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(act, temp, fault, miss);
    endtask

    // stop offering and wait for every outstanding status to come back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_write(htsl_pkg::t_reg_idx idx, logic [htsl_pkg::DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_reg(idx, val);
        n_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(int crit, int stop_lvl, int start_lvl, int ready_lvl,
                             int retry, int blink_per);
        apb_write(htsl_pkg::REG_CRITICAL, crit);
        apb_write(htsl_pkg::REG_STOP, stop_lvl);
        apb_write(htsl_pkg::REG_START, start_lvl);
        apb_write(htsl_pkg::REG_NOT_READY, ready_lvl);
        apb_write(htsl_pkg::REG_RETRY, retry);
        apb_write(htsl_pkg::REG_BLINK, blink_per);
    endtask

    task automatic configure_random(bit keep_running, int blink_per);
        configure(keep_running ? $urandom_range(4095, 1) : $urandom_range(4095),
                  $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                  $urandom_range(15), blink_per);
    endtask

    function automatic logic [htsl_pkg::TEMP_W-1:0] near_level(
            logic [htsl_pkg::TEMP_W-1:0] lvl);
        int t;
        t = int'(lvl) + $urandom_range(4) - 2;
        if (t < 0)
            t = 0;
        if (t > 4095)
            t = 4095;
        return t[htsl_pkg::TEMP_W-1:0];
    endfunction

    // keep_running avoids every halt cause so the thermostat path stays live
    task automatic random_request(bit keep_running);
        int                          pick;
        int                          raw;
        logic [1:0]                  act;
        logic [htsl_pkg::TEMP_W-1:0] temp;
        logic                        fault, miss;
        pick = $urandom_range(99);
        if (keep_running) begin
            if (pick < 20)      act = htsl_pkg::ACT_TICK;
            else if (pick < 65) act = htsl_pkg::ACT_BLOCK;
            else if (pick < 95) act = htsl_pkg::ACT_CASE;
            else                act = ACT_UNUSED;
        end else begin
            if (pick < 50)      act = htsl_pkg::ACT_TICK;
            else if (pick < 72) act = htsl_pkg::ACT_BLOCK;
            else if (pick < 95) act = htsl_pkg::ACT_CASE;
            else                act = ACT_UNUSED;
        end
        case ($urandom_range(4))
            0:       temp = near_level(sb.start_lvl);
            1:       temp = near_level(sb.stop_lvl);
            2:       temp = near_level(sb.ready_lvl);
            3:       temp = near_level(sb.crit);
            default: begin
                raw  = $urandom_range(4095);
                temp = raw[htsl_pkg::TEMP_W-1:0];
            end
        endcase
        fault = ($urandom_range(99) < 15);
        miss  = ($urandom_range(99) < 60);
        if (keep_running) begin
            if (act == htsl_pkg::ACT_BLOCK) begin
                fault = 1'b0;
                if (temp >= sb.crit) begin
                    raw  = $urandom_range(int'(sb.crit) - 1);
                    temp = raw[htsl_pkg::TEMP_W-1:0];
                end
            end
            if (act == htsl_pkg::ACT_CASE && miss && sb.miss_cnt < htsl_pkg::MISSING_MAX &&
                int'(sb.miss_cnt) + 1 == int'(sb.retry))
                miss = 1'b0;
        end
        send_request(act, temp, fault, miss);
    endtask

    task automatic random_run(bit keep_running, int count);
        repeat (count) random_request(keep_running);
        drain();
    endtask

    initial begin
        #(12 * 200000);
        $display("FAIL heater_thermostat_safety_latch");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: walk the hysteresis band and the ready levels
        send_request(htsl_pkg::ACT_TICK, 12'd0, 1'b1, 1'b1);
        send_request(ACT_UNUSED, 12'hFFF, 1'b1, 1'b1);
        send_request(htsl_pkg::ACT_BLOCK, 12'd760, 1'b0, 1'b1);
        send_request(htsl_pkg::ACT_BLOCK, 12'd780, 1'b0, 1'b0);
        send_request(htsl_pkg::ACT_BLOCK, 12'd800, 1'b0, 1'b0);
        send_request(htsl_pkg::ACT_BLOCK, 12'd799, 1'b0, 1'b0);
        send_request(htsl_pkg::ACT_BLOCK, 12'd761, 1'b0, 1'b0);
        send_request(htsl_pkg::ACT_BLOCK, 12'd760, 1'b0, 1'b0);
        send_request(htsl_pkg::ACT_BLOCK, 12'd599, 1'b0, 1'b0);
        send_request(htsl_pkg::ACT_BLOCK, 12'd600, 1'b0, 1'b0);
        send_request(htsl_pkg::ACT_BLOCK, 12'd0, 1'b0, 1'b0);
        send_request(htsl_pkg::ACT_BLOCK, 12'd1199, 1'b0, 1'b0);
        send_request(htsl_pkg::ACT_CASE, 12'd0, 1'b0, 1'b0);
        repeat (4) send_request(htsl_pkg::ACT_CASE, 12'd0, 1'b0, 1'b1);
        send_request(htsl_pkg::ACT_CASE, 12'd0, 1'b1, 1'b0);
        drain();

        // retry limit zero: missing polls saturate the count and never halt
        configure(4095, 4094, 4093, 4095, 0, 0);
        repeat (17) send_request(htsl_pkg::ACT_CASE, 12'd0, 1'b0, 1'b1);
        send_request(htsl_pkg::ACT_BLOCK, 12'd4094, 1'b0, 1'b0);
        send_request(htsl_pkg::ACT_BLOCK, 12'd4093, 1'b0, 1'b0);
        hold_go = 1'b1;
        random_run(1'b1, 90);

        // full count with limit fifteen does not trigger again
        configure(4095, 2048, 1024, 512, 0, 65535);
        repeat (16) send_request(htsl_pkg::ACT_CASE, 12'd0, 1'b0, 1'b1);
        drain();
        apb_write(htsl_pkg::REG_RETRY, 15);
        send_request(htsl_pkg::ACT_CASE, 12'd0, 1'b0, 1'b1);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        random_run(1'b1, 90);
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;

        configure(1, 0, 0, 0, 1, 1);
        send_request(htsl_pkg::ACT_BLOCK, 12'd0, 1'b0, 1'b0);
        random_run(1'b1, 60);
        configure(2000, 300, 1500, 4095, 3, 7);
        random_run(1'b1, 90);
        repeat (2) begin
            configure_random(1'b1, $urandom_range(65535));
            random_run(1'b1, 90);
        end

        // overheat latches with the heater running
        configure(1200, 800, 760, 600, 5, 3);
        send_request(htsl_pkg::ACT_BLOCK, 12'd760, 1'b0, 1'b0);
        send_request(htsl_pkg::ACT_BLOCK, 12'd1200, 1'b0, 1'b0);
        send_request(htsl_pkg::ACT_BLOCK, 12'd100, 1'b0, 1'b0);
        send_request(htsl_pkg::ACT_BLOCK, 12'hFFF, 1'b0, 1'b0);
        send_request(htsl_pkg::ACT_BLOCK, 12'd800, 1'b1, 1'b0);
        repeat (4) send_request(htsl_pkg::ACT_TICK, 12'd0, 1'b0, 1'b0);
        random_run(1'b0, 120);

        // blink period zero toggles on every tick
        configure(0, 4095, 4095, 0, 15, 0);
        random_run(1'b0, 120);
        configure(4095, 0, 0, 4095, 1, 1);
        random_run(1'b0, 120);
        configure_random(1'b0, 65535);
        random_run(1'b0, 100);
        configure_random(1'b0, $urandom_range(12));
        random_run(1'b0, 120);

        repeat (10) @(posedge i_clk);
        $display("run covered %0d ticks, %0d block readings, %0d case polls, %0d unused",
                 sb.n_by_act[htsl_pkg::ACT_TICK], sb.n_by_act[htsl_pkg::ACT_BLOCK],
                 sb.n_by_act[htsl_pkg::ACT_CASE], sb.n_by_act[ACT_UNUSED]);
        $display("%0d results checked, %0d register writes, %0d halt latches, %0d blinks",
                 sb.n_checked, n_writes, sb.n_latch, sb.n_toggle);
        if (sb.n_bad == 0 && sb.pending() == 0) begin
            $display("PASS heater_thermostat_safety_latch");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.n_bad, sb.pending());
            $display("FAIL heater_thermostat_safety_latch");
        end
        $finish;
    end

endmodule

/* files.f */
src/htsl_pkg.sv
src/heater_thermostat_safety_latch.sv
src/htsl_checker.sv
tb/tb.sv
